FILE: hdl/binary_to_decimal_ascii_assert.svh
// Assertion macros for the converter RTL.
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define BTDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define BTDA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/btda_pkg.sv
package btda_pkg;

  localparam int BIN_W      = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int SR_W       = BCD_W + BIN_W;
  localparam int STEP_BITS  = 8;
  localparam int CNT_W      = 4;

  // ASCII '0' is 6'b11_0000, so a digit code is the BCD nibble under this prefix.
  localparam logic [1:0] ASCII_DIGIT_HI = 2'b11;

  // One pipeline beat: the shift register holds {bcd, unconsumed binary bits}.
  typedef struct packed {
    logic            valid;
    logic [SR_W-1:0] sr;
  } btda_beat_t;

  // Eight shift-and-add-3 steps of the double-dabble conversion.
  function automatic logic [SR_W-1:0] dabble_steps(input logic [SR_W-1:0] sr_in);
    logic [SR_W-1:0] sr;
    sr = sr_in;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (sr[BIN_W+4*d +: 4] >= 4'd5) begin
          sr[BIN_W+4*d +: 4] = sr[BIN_W+4*d +: 4] + 4'd3;
        end
      end
      sr = {sr[SR_W-2:0], 1'b0};
    end
    return sr;
  endfunction

  // Number of significant digits, at least one so that zero prints as '0'.
  function automatic logic [CNT_W-1:0] digit_count(input logic [BCD_W-1:0] bcd);
    logic [CNT_W-1:0] n;
    n = CNT_W'(1);
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd[4*d +: 4] != 4'd0) begin
        n = CNT_W'(d + 1);
      end
    end
    return n;
  endfunction

endpackage

FILE: hdl/btda_dabble_stage.sv
module btda_dabble_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  btda_pkg::btda_beat_t  up_i,
  output logic                  up_ready_o,
  output btda_pkg::btda_beat_t  dn_o,
  input  logic                  dn_ready_i
);
  import btda_pkg::*;

  logic            valid_r;
  logic [SR_W-1:0] sr_r;

  // The stage takes a new beat when empty or when its beat moves on this cycle.
  assign up_ready_o = !valid_r || dn_ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready_o) begin
      valid_r <= up_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready_o && up_i.valid) begin
      sr_r <= dabble_steps(up_i.sr);
    end
  end

  assign dn_o.valid = valid_r;
  assign dn_o.sr    = sr_r;

endmodule

FILE: hdl/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter.
//
// Input: a 32-bit unsigned in_value is taken at a rising edge where start is
// high and busy is low. Output: the decimal digits of that value as ASCII codes,
// most significant first, without leading zeros (zero gives a single '0').
// Each digit is shown for one cycle with out_strobe high; out_last marks the
// final digit of the item. The receiver cannot hold results off.
//
// An accepted item passes through the dabble stages in turn and then the
// output register, which shows its first digit; the rest follow one per cycle.
// Four double-dabble stages of eight bits each do the conversion, and an
// output shift register sends one digit per cycle.
// Throughput: an item can enter every cycle while the stages have room; in
// steady state each item's digits (1 to 10) run on from the last item's, since
// the output register loads the next item in the cycle its last digit leaves.
// busy is high while the first stage is full and cannot move on.
//
// Reset (rst_n low, synchronous) empties all stages and the output register.
`include "binary_to_decimal_ascii_assert.svh"

module binary_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_value,
  output logic        out_strobe,
  output logic [5:0]  out_digit_char,
  output logic        out_last
);
  import btda_pkg::*;

  localparam int NUM_STAGES = BIN_W / STEP_BITS;

  btda_beat_t              beat   [NUM_STAGES+1];
  logic [NUM_STAGES:0]     ready;

  logic                    ser_v_r;
  logic [BCD_W-1:0]        ser_digits_r;
  logic [BCD_W-1:0]        ser_digits_nxt;
  logic [CNT_W-1:0]        ser_left_r;
  logic [CNT_W-1:0]        ser_left_nxt;
  logic [CNT_W-1:0]        lead_zeros;
  logic [BCD_W-1:0]        done_bcd;
  logic                    ser_take;

  assign beat[0].valid = start;
  assign beat[0].sr    = {{BCD_W{1'b0}}, in_value};
  assign busy          = !ready[0];

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    btda_dabble_stage u_stage (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_i       (beat[g]),
      .up_ready_o (ready[g]),
      .dn_o       (beat[g+1]),
      .dn_ready_i (ready[g+1])
    );
  end

  // The output register refills in the cycle its last digit goes out.
  assign ser_take          = !ser_v_r || (ser_left_r == CNT_W'(1));
  assign ready[NUM_STAGES] = ser_take;

  // Left-align the most significant nonzero digit before shifting out.
  assign done_bcd       = beat[NUM_STAGES].sr[SR_W-1 -: BCD_W];
  assign ser_left_nxt   = digit_count(done_bcd);
  assign lead_zeros     = CNT_W'(NUM_DIGITS) - ser_left_nxt;
  assign ser_digits_nxt = done_bcd << {lead_zeros, 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
    end else if (ser_take) begin
      ser_v_r <= beat[NUM_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take) begin
      ser_digits_r <= ser_digits_nxt;
      ser_left_r   <= ser_left_nxt;
    end else if (ser_v_r) begin
      ser_digits_r <= {ser_digits_r[BCD_W-5:0], 4'd0};
      ser_left_r   <= ser_left_r - CNT_W'(1);
    end
  end

  assign out_strobe     = ser_v_r;
  assign out_digit_char = {ASCII_DIGIT_HI, ser_digits_r[BCD_W-1 -: 4]};
  assign out_last       = ser_v_r && (ser_left_r == CNT_W'(1));

  `BTDA_ASSERT_NXT(a_digits_continue, out_strobe && !out_last, out_strobe, "digit run broken before last")
  `BTDA_ASSERT_IMP(a_left_range, ser_v_r, (ser_left_r != '0) && (ser_left_r <= CNT_W'(NUM_DIGITS)), "digit count out of range")
  `BTDA_ASSERT_NXT(a_tail_holds, beat[NUM_STAGES].valid && !ser_take, beat[NUM_STAGES].valid && $stable(beat[NUM_STAGES].sr), "stalled item lost")

endmodule
